### hdl/epoch_seconds_to_calendar_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the epoch-to-calendar block
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH

// implication checked every clock, off while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Types, constants and helpers for the epoch-to-calendar pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package esc_pkg;
    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned EpochYear   = 1970;
    localparam int unsigned MaxYears    = 137;
    localparam int unsigned OffsetW     = 17;
    localparam int unsigned CfgAddrW    = 1;
    localparam logic [CfgAddrW-1:0] RegZoneOffset = 1'b0;

    typedef struct packed {
        logic [11:0] cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_day;
        logic [4:0]  cal_hour;
        logic [5:0]  cal_minute;
        logic [5:0]  cal_second;
        logic [2:0]  week_day;
    } t_cal;

    // days before the first of each month (non-leap), index 0..12
    function automatic logic [8:0] f_cum_days(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd365;
        endcase
        return v;
    endfunction

    // days from epoch to Jan 1 of year 1970+k; 2100 is not leap
    function automatic logic [15:0] f_year_start(input logic [7:0] k);
        logic [8:0]  y;
        logic [15:0] v;
        y = 9'(k) + 9'd1;
        v = 16'(k) * 16'd365 + 16'(y >> 2);
        if (k > 8'd130) begin
            v = v - 16'd1;
        end
        return v;
    endfunction

    function automatic logic f_leap(input logic [7:0] k);
        logic [11:0] y;
        y = 12'(k) + 12'(EpochYear);
        return (y[1:0] == 2'b00) && (y != 12'd2100);
    endfunction
endpackage
`default_nettype wire

### hdl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Stages 1-2: zone offset add with clamp, split into days and time of day.
// ----------------------------------------------------------------------------
`default_nettype none
module esc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [31:0]                   i_secs,
    input  wire logic signed [esc_pkg::OffsetW-1:0] i_offset,
    output logic                               o_valid,
    output logic [15:0]                        o_days,
    output logic [16:0]                        o_tod
);
    import esc_pkg::*;

    logic        r_v1, r_v2;
    logic [31:0] r_secs;
    logic [15:0] r_days;
    logic [16:0] r_tod;
    logic signed [33:0] n_sum;
    logic [31:0] n_secs;
    logic [47:0] n_prod;
    logic [15:0] n_q;
    logic [33:0] n_rem;

    always_comb begin
        n_sum = $signed({2'b00, i_secs}) + 34'(i_offset);
        if (n_sum[33]) begin
            n_secs = '0;
        end else if (n_sum[32]) begin
            n_secs = '1;
        end else begin
            n_secs = n_sum[31:0];
        end
    end

    // days = secs / 86400 via reciprocal, then one correction step
    always_comb begin
        n_prod = 48'(r_secs[31:7]) * 48'd6362914;
        n_q    = n_prod[47:32];
        n_rem  = 34'(r_secs) - 34'(n_q) * 34'(SecsPerDay);
        if (n_rem >= 34'(SecsPerDay)) begin
            n_q   = n_q + 16'd1;
            n_rem = n_rem - 34'(SecsPerDay);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_secs <= n_secs;
            r_days <= n_q;
            r_tod  <= n_rem[16:0];
        end
    end

    assign o_valid = r_v2;
    assign o_days  = r_days;
    assign o_tod   = r_tod;
endmodule
`default_nettype wire

### hdl/esc_date.sv
// ----------------------------------------------------------------------------
// esc_date
// Stages 3-5: year estimate and fix, month search, time of day and weekday.
// ----------------------------------------------------------------------------
`default_nettype none
module esc_date (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [15:0]    i_days,
    input  wire logic [16:0]    i_tod,
    output logic                o_valid,
    output esc_pkg::t_cal       o_cal
);
    import esc_pkg::*;

    // stage 3
    logic        r_v3;
    logic [7:0]  r_k3;
    logic [15:0] r_d3;
    logic [16:0] r_t3;
    // stage 4
    logic        r_v4;
    logic [7:0]  r_k4;
    logic [8:0]  r_doy4;
    logic [15:0] r_d4;
    logic [4:0]  r_h4;
    logic [11:0] r_ts4;
    // stage 5
    logic        r_v5;
    t_cal        r_c5;

    logic [7:0]  n_k;
    logic [7:0]  n_kf;
    logic [15:0] n_ys;
    logic [8:0]  n_doy;
    logic [3:0]  n_m;
    logic [8:0]  n_base;
    logic        n_lp;
    logic [8:0]  n_cm;
    logic [5:0]  n_min;
    logic [2:0]  n_wd;
    logic [15:0] n_w;

    // coarse year: days / 365, may be one high
    always_comb begin
        n_k = 8'(({16'd0, i_days} * 32'd45965) >> 24);
    end

    always_comb begin
        n_kf = r_k3;
        if (f_year_start(r_k3) > r_d3) begin
            n_kf = r_k3 - 8'd1;
        end
        n_ys  = f_year_start(n_kf);
        n_doy = 9'(r_d3 - n_ys);
    end

    always_comb begin
        n_lp = f_leap(r_k4);
        n_m  = 4'd1;
        for (int i = 1; i < 12; i++) begin
            n_cm = f_cum_days(4'(i)) + ((n_lp && i >= 2) ? 9'd1 : 9'd0);
            if (r_doy4 >= n_cm) begin
                n_m = 4'(i + 1);
            end
        end
        n_base = f_cum_days(n_m - 4'd1) + ((n_lp && n_m > 4'd2) ? 9'd1 : 9'd0);
        n_min  = 6'(({20'd0, r_ts4} * 32'd69906) >> 22);
        n_w    = r_d4 + 16'd4;
        n_wd   = 3'(n_w - 16'((({16'd0, n_w} * 32'd74899) >> 19) * 32'd7));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k3  <= n_k;
            r_d3  <= i_days;
            r_t3  <= i_tod;
            r_k4  <= n_kf;
            r_doy4 <= n_doy;
            r_d4  <= r_d3;
            r_h4  <= 5'(({15'd0, r_t3} * 32'd37283) >> 27);
            r_ts4 <= 12'(r_t3 - 17'(({15'd0, r_t3} * 32'd37283) >> 27) * 17'd3600);
            r_c5.cal_year   <= 12'(r_k4) + 12'(EpochYear);
            r_c5.cal_month  <= n_m;
            r_c5.cal_day    <= 5'(r_doy4 - n_base + 9'd1);
            r_c5.cal_hour   <= r_h4;
            r_c5.cal_minute <= n_min;
            r_c5.cal_second <= 6'(r_ts4 - 12'(n_min) * 12'd60);
            r_c5.week_day   <= n_wd;
        end
    end

    assign o_valid = r_v5;
    assign o_cal   = r_c5;
endmodule
`default_nettype wire

### hdl/epoch_seconds_to_calendar_top.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Unix seconds to civil date and time, five-stage pipeline.
// ----------------------------------------------------------------------------
// Input beat: s_axis_tdata[31:0] = epoch_seconds.
// Output beat: m_axis_tdata = cal_year, month, day, hour, minute, second,
// week_day from the lowest bit up (41 bits in 48).
// APB register 0 (address 0): zone_offset_seconds, 17-bit signed, reset 0.
// One beat per cycle is sustained while m_axis_tready stays high.
// The whole pipeline advances when the output slot is empty or taken, so a
// stalled receiver holds every stage and s_axis_tready drops; nothing is
// lost or repeated. Reset clears all stage valid bits and the offset.
// ----------------------------------------------------------------------------
`default_nettype none
module epoch_seconds_to_calendar_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // epoch_seconds
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // year,month,day,hour,min,sec,wday
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [esc_pkg::CfgAddrW+1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import esc_pkg::*;

    logic signed [OffsetW-1:0] r_offset;
    logic        w_en, w_fv;
    logic [15:0] w_days;
    logic [16:0] w_tod;
    t_cal        w_cal;

    assign pready = 1'b1;
    assign prdata = (paddr[CfgAddrW+1:2] == RegZoneOffset) ? 32'(r_offset) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (psel && penable && pwrite
                     && paddr[CfgAddrW+1:2] == RegZoneOffset) begin
            r_offset <= pwdata[OffsetW-1:0];
        end
    end

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    esc_front u_front (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(s_axis_tvalid),
        .i_secs(s_axis_tdata), .i_offset(r_offset),
        .o_valid(w_fv), .o_days(w_days), .o_tod(w_tod)
    );

    esc_date u_date (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_fv),
        .i_days(w_days), .i_tod(w_tod),
        .o_valid(m_axis_tvalid), .o_cal(w_cal)
    );

    assign m_axis_tdata = {7'd0, w_cal.week_day, w_cal.cal_second, w_cal.cal_minute,
                           w_cal.cal_hour, w_cal.cal_day, w_cal.cal_month, w_cal.cal_year};
endmodule
`default_nettype wire

### hdl/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks on the output stream of the calendar block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "epoch_seconds_to_calendar_top_defines.svh"
module esc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat dropped")
    `ASSERT_IMPL(a_stall, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "accepts while stalled")
    `ASSERT_IMPL(a_month, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[15:12] != 4'd0 && m_axis_tdata[15:12] < 4'd13, "bad month")
    `ASSERT_IMPL(a_time, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[25:21] < 5'd24 && m_axis_tdata[37:32] < 6'd60 && m_axis_tdata[40:38] < 3'd7, "bad time")
endmodule

bind epoch_seconds_to_calendar_top esc_checker u_chk (
    .i_clk, .i_rst_n, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
